@@ design/onewire_bus_master_assert.svh @@
// Assertion macros for the 1-Wire bus master.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef ONEWIRE_BUS_MASTER_ASSERT_SVH
`define ONEWIRE_BUS_MASTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define OWBM_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OWBM_ASSERT(lbl, expr, msg)
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/owbm_pkg.sv @@
`default_nettype none

package owbm_pkg;

    localparam int COUNT_WIDTH = 10;
    localparam int CFG_WIDTH = 10;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0] ticks_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [2:0] kind_t;

    localparam count_t COUNT_MAX = '1;

    // Request kinds.
    localparam kind_t KIND_TICK  = 3'd0;
    localparam kind_t KIND_RESET = 3'd1;
    localparam kind_t KIND_WRITE = 3'd2;
    localparam kind_t KIND_READ  = 3'd3;
    localparam kind_t KIND_POWER = 3'd4;

    // Configuration register indexes.
    localparam cfg_index_t CFG_WRITE_ZERO_LOW = 3'd0;
    localparam cfg_index_t CFG_WRITE_ONE_LOW  = 3'd1;
    localparam cfg_index_t CFG_WRITE_SLOT     = 3'd2;
    localparam cfg_index_t CFG_READ_LOW       = 3'd3;
    localparam cfg_index_t CFG_READ_SAMPLE    = 3'd4;
    localparam cfg_index_t CFG_READ_RECOVERY  = 3'd5;
    localparam cfg_index_t CFG_RESET_LOW      = 3'd6;
    localparam cfg_index_t CFG_PRESENCE_WAIT  = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRITE,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_REC,
        PH_RS_LOW,
        PH_RS_WAIT,
        PH_RS_REC
    } phase_t;

    typedef struct packed {
        ticks_t write_zero_low;
        ticks_t write_one_low;
        ticks_t write_slot;
        ticks_t read_low;
        ticks_t read_sample;
        ticks_t read_recovery;
        ticks_t reset_low;
        ticks_t presence_wait;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        count_t      tick_count;
        logic [2:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [1:0]  status_bits;
        logic        power_level;
        logic        line_drive;
        logic [7:0]  last_read;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:       PH_IDLE,
        tick_count:  '0,
        bit_index:   '0,
        shift_byte:  '0,
        status_bits: '0,
        power_level: 1'b1,
        line_drive:  1'b0,
        last_read:   '0
    };

    // An interval is over once the count reaches its length, or when the
    // counter has saturated.
    function automatic logic reached(count_t cnt, ticks_t len);
        logic [CMP_WIDTH-1:0] cnt_ext;
        logic [CMP_WIDTH-1:0] len_ext;
        cnt_ext = CMP_WIDTH'(cnt);
        len_ext = CMP_WIDTH'(len);
        return (cnt_ext >= len_ext) || (cnt == COUNT_MAX);
    endfunction

endpackage

`default_nettype wire

@@ design/onewire_bus_master.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    kind, data_byte, line_level
// output    out        out_valid / out_ready  drive_low, power_on, busy_res, done_res,
//                                             read_data, reset_status, rejected
// config    in         cfg_write_en           cfg_index, cfg_data
//
// Each request updates the bus state and its result lands in the output register at the
// same clock edge, so one request is accepted per cycle while the output is not held.
// in_ready drops only while the output register holds a result that out_ready refuses.
// After reset the bus state has the line released and the power level high (the result
// registers are not reset), and the timing registers hold their standard 1-Wire values.
`default_nettype none

module onewire_bus_master (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire owbm_pkg::kind_t      kind,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 line_level,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      drive_low,
    output logic                      power_on,
    output logic                      busy_res,
    output logic                      done_res,
    output logic [7:0]                read_data,
    output logic [1:0]                reset_status,
    output logic                      rejected,
    input  wire logic                 cfg_write_en,
    input  wire owbm_pkg::cfg_index_t cfg_index,
    input  wire owbm_pkg::ticks_t     cfg_data
);

`include "onewire_bus_master_assert.svh"

    owbm_pkg::cfg_t   cfg;
    owbm_pkg::state_t state_reg;
    owbm_pkg::state_t state_next;
    logic             step_done;
    logic             step_rejected;
    logic             in_accept;
    logic             cmd_busy;

    logic             out_valid_reg;
    logic             drive_low_reg;
    logic             power_on_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [7:0]       read_data_reg;
    logic [1:0]       reset_status_reg;
    logic             rejected_reg;

    owbm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg)
    );

    owbm_step u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .kind       (kind),
        .data_byte  (data_byte),
        .line_level (line_level),
        .nxt        (state_next),
        .done       (step_done),
        .rejected   (step_rejected)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign cmd_busy = (state_reg.phase != owbm_pkg::PH_IDLE)
                   && (kind inside {owbm_pkg::KIND_RESET, owbm_pkg::KIND_WRITE,
                                    owbm_pkg::KIND_READ, owbm_pkg::KIND_POWER});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= owbm_pkg::STATE_RESET;
        else if (in_accept)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // The result shows the bus state after the request.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            drive_low_reg    <= state_next.line_drive;
            power_on_reg     <= state_next.power_level;
            busy_reg         <= state_next.phase != owbm_pkg::PH_IDLE;
            done_reg         <= step_done;
            read_data_reg    <= state_next.last_read;
            reset_status_reg <= state_next.status_bits;
            rejected_reg     <= step_rejected;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_low    = drive_low_reg;
    assign power_on     = power_on_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign read_data    = read_data_reg;
    assign reset_status = reset_status_reg;
    assign rejected     = rejected_reg;

    `OWBM_ASSERT(a_ready_when_empty, !out_valid_reg |-> in_ready, "input stalled with empty output")
    `OWBM_ASSERT_NEXT(a_busy_reject, in_accept && cmd_busy, rejected_reg && busy_reg, "busy reject")
    `OWBM_ASSERT(a_done_idle, out_valid_reg && done_reg |-> !busy_reg, "done reported while still busy")
    `OWBM_ASSERT(a_drive_busy, out_valid_reg && drive_low_reg |-> busy_reg, "line pulled low while idle")

endmodule

`default_nettype wire

@@ design/owbm_cfg.sv @@
`default_nettype none

module owbm_cfg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 write_en,
    input  wire owbm_pkg::cfg_index_t index,
    input  wire owbm_pkg::ticks_t     data,
    output owbm_pkg::cfg_t            cfg
);

    owbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_zero_low <= owbm_pkg::CFG_WIDTH'(58);
            cfg_reg.write_one_low  <= owbm_pkg::CFG_WIDTH'(8);
            cfg_reg.write_slot     <= owbm_pkg::CFG_WIDTH'(64);
            cfg_reg.read_low       <= owbm_pkg::CFG_WIDTH'(5);
            cfg_reg.read_sample    <= owbm_pkg::CFG_WIDTH'(10);
            cfg_reg.read_recovery  <= owbm_pkg::CFG_WIDTH'(50);
            cfg_reg.reset_low      <= owbm_pkg::CFG_WIDTH'(500);
            cfg_reg.presence_wait  <= owbm_pkg::CFG_WIDTH'(100);
        end
        else if (write_en)
        begin
            case (index)
                owbm_pkg::CFG_WRITE_ZERO_LOW: cfg_reg.write_zero_low <= data;
                owbm_pkg::CFG_WRITE_ONE_LOW:  cfg_reg.write_one_low  <= data;
                owbm_pkg::CFG_WRITE_SLOT:     cfg_reg.write_slot     <= data;
                owbm_pkg::CFG_READ_LOW:       cfg_reg.read_low       <= data;
                owbm_pkg::CFG_READ_SAMPLE:    cfg_reg.read_sample    <= data;
                owbm_pkg::CFG_READ_RECOVERY:  cfg_reg.read_recovery  <= data;
                owbm_pkg::CFG_RESET_LOW:      cfg_reg.reset_low      <= data;
                owbm_pkg::CFG_PRESENCE_WAIT:  cfg_reg.presence_wait  <= data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/owbm_step.sv @@
`default_nettype none

module owbm_step (
    input  wire owbm_pkg::state_t cur,
    input  wire owbm_pkg::cfg_t   cfg,
    input  wire owbm_pkg::kind_t  kind,
    input  wire logic [7:0]       data_byte,
    input  wire logic             line_level,
    output owbm_pkg::state_t      nxt,
    output logic                  done,
    output logic                  rejected
);

    owbm_pkg::phase_t phase_next;
    owbm_pkg::count_t tick_inc;
    owbm_pkg::ticks_t low_len;
    owbm_pkg::ticks_t phase_len;
    logic             busy;
    logic             is_cmd;
    logic             tick_run;
    logic             interval_end;
    logic             last_bit;

    assign busy     = cur.phase != owbm_pkg::PH_IDLE;
    assign is_cmd   = kind inside {owbm_pkg::KIND_RESET, owbm_pkg::KIND_WRITE,
                                   owbm_pkg::KIND_READ, owbm_pkg::KIND_POWER};
    assign rejected = is_cmd && busy;
    assign tick_run = (kind == owbm_pkg::KIND_TICK) && busy;
    assign last_bit = cur.bit_index == '1;

    assign tick_inc = (cur.tick_count == owbm_pkg::COUNT_MAX)
                    ? cur.tick_count : cur.tick_count + owbm_pkg::count_t'(1);

    assign low_len = cur.shift_byte[cur.bit_index] ? cfg.write_one_low
                                                   : cfg.write_zero_low;

    always_comb
    begin
        case (cur.phase)
            owbm_pkg::PH_WRITE:   phase_len = cfg.write_slot;
            owbm_pkg::PH_RD_LOW:  phase_len = cfg.read_low;
            owbm_pkg::PH_RD_WAIT: phase_len = cfg.read_sample;
            owbm_pkg::PH_RD_REC:  phase_len = cfg.read_recovery;
            owbm_pkg::PH_RS_LOW:  phase_len = cfg.reset_low;
            owbm_pkg::PH_RS_WAIT: phase_len = cfg.presence_wait;
            owbm_pkg::PH_RS_REC:  phase_len = cfg.reset_low;
            default:              phase_len = cfg.reset_low;
        endcase
    end

    assign interval_end = owbm_pkg::reached(tick_inc, phase_len);

    // Next phase.
    always_comb
    begin
        phase_next = cur.phase;
        if (!busy)
        begin
            case (kind)
                owbm_pkg::KIND_RESET: phase_next = owbm_pkg::PH_RS_LOW;
                owbm_pkg::KIND_WRITE: phase_next = owbm_pkg::PH_WRITE;
                owbm_pkg::KIND_READ:  phase_next = owbm_pkg::PH_RD_LOW;
                default:              phase_next = cur.phase;
            endcase
        end
        else if (tick_run && interval_end)
        begin
            case (cur.phase)
                owbm_pkg::PH_WRITE:
                    phase_next = last_bit ? owbm_pkg::PH_IDLE : owbm_pkg::PH_WRITE;
                owbm_pkg::PH_RD_LOW:  phase_next = owbm_pkg::PH_RD_WAIT;
                owbm_pkg::PH_RD_WAIT: phase_next = owbm_pkg::PH_RD_REC;
                owbm_pkg::PH_RD_REC:
                    phase_next = last_bit ? owbm_pkg::PH_IDLE : owbm_pkg::PH_RD_LOW;
                owbm_pkg::PH_RS_LOW:  phase_next = owbm_pkg::PH_RS_WAIT;
                owbm_pkg::PH_RS_WAIT: phase_next = owbm_pkg::PH_RS_REC;
                owbm_pkg::PH_RS_REC:  phase_next = owbm_pkg::PH_IDLE;
                default:              phase_next = cur.phase;
            endcase
        end
    end

    // Counter, shift register, line drive and status.
    always_comb
    begin
        nxt       = cur;
        nxt.phase = phase_next;
        done      = 1'b0;
        if (!busy)
        begin
            case (kind)
                owbm_pkg::KIND_RESET:
                begin
                    nxt.status_bits = '0;
                    nxt.tick_count  = '0;
                    nxt.line_drive  = 1'b1;
                end
                owbm_pkg::KIND_WRITE:
                begin
                    nxt.shift_byte = data_byte;
                    nxt.bit_index  = '0;
                    nxt.tick_count = '0;
                    nxt.line_drive = 1'b1;
                end
                owbm_pkg::KIND_READ:
                begin
                    nxt.shift_byte = '0;
                    nxt.bit_index  = '0;
                    nxt.tick_count = '0;
                    nxt.line_drive = 1'b1;
                end
                owbm_pkg::KIND_POWER:
                    nxt.power_level = data_byte[0];
                default: ;
            endcase
        end
        else if (tick_run)
        begin
            nxt.tick_count = tick_inc;
            case (cur.phase)
                owbm_pkg::PH_WRITE:
                begin
                    if (owbm_pkg::reached(tick_inc, low_len))
                        nxt.line_drive = 1'b0;
                    if (interval_end)
                    begin
                        if (last_bit)
                        begin
                            nxt.line_drive = 1'b0;
                            done           = 1'b1;
                        end
                        else
                        begin
                            nxt.bit_index  = cur.bit_index + 3'd1;
                            nxt.tick_count = '0;
                            nxt.line_drive = 1'b1;
                        end
                    end
                end
                owbm_pkg::PH_RD_LOW, owbm_pkg::PH_RS_LOW:
                begin
                    if (interval_end)
                    begin
                        nxt.line_drive = 1'b0;
                        nxt.tick_count = '0;
                    end
                end
                owbm_pkg::PH_RD_WAIT:
                begin
                    if (interval_end)
                    begin
                        nxt.shift_byte[cur.bit_index] =
                            cur.shift_byte[cur.bit_index] | line_level;
                        nxt.tick_count = '0;
                    end
                end
                owbm_pkg::PH_RD_REC:
                begin
                    if (interval_end)
                    begin
                        if (last_bit)
                        begin
                            nxt.last_read = cur.shift_byte;
                            done          = 1'b1;
                        end
                        else
                        begin
                            nxt.bit_index  = cur.bit_index + 3'd1;
                            nxt.tick_count = '0;
                            nxt.line_drive = 1'b1;
                        end
                    end
                end
                owbm_pkg::PH_RS_WAIT:
                begin
                    if (interval_end)
                    begin
                        // A high line at the check means no slave answered.
                        if (line_level)
                            nxt.status_bits[0] = 1'b1;
                        nxt.tick_count = '0;
                    end
                end
                owbm_pkg::PH_RS_REC:
                begin
                    if (interval_end)
                    begin
                        if (!line_level)
                            nxt.status_bits[1] = 1'b1;
                        done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire
